/* rtl/bde_pkg.sv */
// Shared types and constants for the button debouncer with edge detection.
package bde_pkg;

  localparam int unsigned CountW = 16;

  // Confirm counts below MinCount are replaced by DefaultCount.
  localparam logic [CountW-1:0] MinCount     = 16'd2;
  localparam logic [CountW-1:0] DefaultCount = 16'd3;

  // Value of the confirm count register out of reset.
  localparam logic [CountW-1:0] ConfirmReset = 16'd3;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgActiveHigh   = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgConfirmCount = 1'd1;

  typedef enum logic [1:0] {
    PH_IDLE        = 2'd0,
    PH_CONF_ACTIVE = 2'd1,
    PH_ACTIVE      = 2'd2,
    PH_CONF_IDLE   = 2'd3
  } phase_e;

endpackage

/* rtl/bde_in_if.sv */
// Input channel carrying one raw pin sample per beat.
interface bde_in_if;
  logic valid;
  logic ready;
  logic raw_level;

  modport source (output valid, output raw_level, input ready);
  modport sink   (input valid, input raw_level, output ready);
endinterface

/* rtl/bde_out_if.sv */
// Output channel carrying the debounced level and edge pulses per beat.
interface bde_out_if;
  logic valid;
  logic ready;
  logic is_active;
  logic rose_to_active;
  logic fell_to_idle;

  modport source (output valid, output is_active, output rose_to_active,
                  output fell_to_idle, input ready);
  modport sink   (input valid, input is_active, input rose_to_active,
                  input fell_to_idle, output ready);
endinterface

/* rtl/button_debounce_edge_detect_core.sv */
// Top level of the counter-based button debouncer with edge detection.
//
// Each input beat is one raw pin sample and produces exactly one output beat.
// A sample is active when it equals the polarity register. A change of the
// debounced level is validated once the stable-sample counter reaches the
// effective confirm count (confirm_count, or DefaultConfirm when confirm_count
// is below MinConfirm); the first differing sample starts the count at 1 and is
// never itself the validating one. rose_to_active and fell_to_idle pulse on the
// beat that validates a change. The registered result is output in the cycle
// after its input beat is accepted. A new sample is accepted every cycle unless
// the output is stalled: the phase machine and 16-bit counter step per beat,
// and the output register refills in the same cycle the previous one is taken.
module button_debounce_edge_detect_core #(
  parameter logic [bde_pkg::CountW-1:0] MinConfirm     = bde_pkg::MinCount,
  parameter logic [bde_pkg::CountW-1:0] DefaultConfirm = bde_pkg::DefaultCount
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bde_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bde_pkg::CountW-1:0]   cfg_wdata_i,
  bde_in_if.sink                       in_ch,
  bde_out_if.source                    out_ch
);
  import bde_pkg::*;

  logic              pol_high_q;
  logic [CountW-1:0] confirm_count_q;

  phase_e            phase_q, phase_d;
  logic [CountW-1:0] count_q, count_d;

  logic              out_valid_q;
  logic              is_active_q, rose_q, fell_q;
  logic              is_active_d, rose_d, fell_d;

  logic              accept;
  logic              act;
  logic [CountW-1:0] eff_count;
  logic [CountW-1:0] count_inc;
  logic              reached;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_high_q      <= 1'b1;
      confirm_count_q <= ConfirmReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgActiveHigh:   pol_high_q      <= cfg_wdata_i[0];
        CfgConfirmCount: confirm_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign act       = (in_ch.raw_level == pol_high_q);
  assign eff_count = (confirm_count_q < MinConfirm) ? DefaultConfirm : confirm_count_q;
  assign count_inc = (count_q == CountMax) ? count_q : count_q + CountW'(1);
  assign reached   = (count_inc >= eff_count);

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_IDLE:        if (act) phase_d = PH_CONF_ACTIVE;
      PH_CONF_ACTIVE: begin
        if (!act)         phase_d = PH_IDLE;
        else if (reached) phase_d = PH_ACTIVE;
      end
      PH_ACTIVE:      if (!act) phase_d = PH_CONF_IDLE;
      PH_CONF_IDLE: begin
        if (act)          phase_d = PH_ACTIVE;
        else if (reached) phase_d = PH_IDLE;
      end
      default:        phase_d = PH_IDLE;
    endcase
  end

  // Counter and result for the current sample.
  always_comb begin
    count_d = count_q;
    rose_d  = 1'b0;
    fell_d  = 1'b0;
    case (phase_q)
      PH_IDLE:        if (act) count_d = CountW'(1);
      PH_CONF_ACTIVE: begin
        if (!act) begin
          count_d = '0;
        end else if (reached) begin
          count_d = '0;
          rose_d  = 1'b1;
        end else begin
          count_d = count_inc;
        end
      end
      PH_ACTIVE:      if (!act) count_d = CountW'(1);
      PH_CONF_IDLE: begin
        if (act) begin
          count_d = '0;
        end else if (reached) begin
          count_d = '0;
          fell_d  = 1'b1;
        end else begin
          count_d = count_inc;
        end
      end
      default:        count_d = '0;
    endcase
    // The debounced level is high in the active phase and while confirming idle.
    is_active_d = (phase_d == PH_ACTIVE) || (phase_d == PH_CONF_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      is_active_q <= is_active_d;
      rose_q      <= rose_d;
      fell_q      <= fell_d;
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.is_active      = is_active_q;
  assign out_ch.rose_to_active = rose_q;
  assign out_ch.fell_to_idle   = fell_q;

endmodule

/* rtl/bde_checker.sv */
// Port-level checks for the debouncer core, bound to its top level.
module bde_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic is_active_i,
  input logic rose_i,
  input logic fell_i
);

  // A stalled output beat keeps its valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  // An empty output register never holds off the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output register");

  // Every accepted sample yields an output beat in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted sample produced no result");

  // Edge pulses agree with the reported level and never coincide.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(rose_i && !is_active_i) && !(fell_i && is_active_i)
                    && !(rose_i && fell_i))
    else $error("edge pulse inconsistent with debounced level");

endmodule

bind button_debounce_edge_detect_core bde_checker u_bde_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .is_active_i (out_ch.is_active),
  .rose_i      (out_ch.rose_to_active),
  .fell_i      (out_ch.fell_to_idle)
);

/* dv/tb_top.sv */
// Self-checking testbench for the button debouncer with edge detection core.
module tb_top;
  import bde_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned GapPct     = 15;

  // Bounce on press, clean press, bounce on release, clean release (MSB first).
  localparam logic [11:0] ResetSeq = 12'b1011_1101_0000;

  typedef enum logic [1:0] {
    PULSE_NONE = 2'd0,
    PULSE_ROSE = 2'd1,
    PULSE_FELL = 2'd2
  } pulse_e;

  typedef struct packed {
    logic is_active;
    logic rose_to_active;
    logic fell_to_idle;
  } debounce_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we      = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx    = '0;
  logic [CountW-1:0] cfg_wdata   = '0;

  bde_in_if  in_ch ();
  bde_out_if out_ch ();

  button_debounce_edge_detect_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // Pin samples waiting to be sent, and debounced results still owed.
  bit        sample_q[$];
  debounce_t debounce_q[$];

  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          calm   = 1'b0;

  // Shadow copy of the block's registers and state.
  logic              m_pol_high    = 1'b1;
  logic [CountW-1:0] m_confirm     = 16'd3;
  phase_e            m_phase       = PH_IDLE;
  logic [CountW-1:0] m_count       = '0;
  logic              m_level       = 1'b0;
  pulse_e            m_pulse       = PULSE_NONE;

  function automatic logic [CountW-1:0] confirm_target(logic [CountW-1:0] cc);
    return (cc < MinCount) ? DefaultCount : cc;
  endfunction

  function automatic debounce_t debounce_sample(logic raw);
    logic      act;
    debounce_t res;
    act = (raw == m_pol_high);
    case (m_phase)
      PH_IDLE: begin
        m_pulse = PULSE_NONE;
        if (act) begin
          m_count = 16'd1;
          m_phase = PH_CONF_ACTIVE;
        end
      end
      PH_CONF_ACTIVE: begin
        if (act) begin
          if (m_count != CountMax) m_count = m_count + 16'd1;
          if (m_count >= confirm_target(m_confirm)) begin
            m_level = 1'b1;
            m_pulse = PULSE_ROSE;
            m_count = '0;
            m_phase = PH_ACTIVE;
          end
        end else begin
          m_count = '0;
          m_phase = PH_IDLE;
        end
      end
      PH_ACTIVE: begin
        m_pulse = PULSE_NONE;
        if (!act) begin
          m_count = 16'd1;
          m_phase = PH_CONF_IDLE;
        end
      end
      default: begin
        if (!act) begin
          if (m_count != CountMax) m_count = m_count + 16'd1;
          if (m_count >= confirm_target(m_confirm)) begin
            m_level = 1'b0;
            m_pulse = PULSE_FELL;
            m_count = '0;
            m_phase = PH_IDLE;
          end
        end else begin
          m_count = '0;
          m_phase = PH_ACTIVE;
        end
      end
    endcase
    res.is_active      = m_level;
    res.rose_to_active = (m_pulse == PULSE_ROSE);
    res.fell_to_idle   = (m_pulse == PULSE_FELL);
    return res;
  endfunction

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.raw_level = 1'b0;
    out_ch.ready    = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Sample driver: holds a beat until it is taken, then maybe inserts a gap.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid     <= 1'b0;
      in_ch.raw_level <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin : drive
      bit gap;
      gap = !calm && ($urandom_range(99) < GapPct);
      if (in_ch.valid) debounce_q.push_back(debounce_sample(in_ch.raw_level));
      if (sample_q.size() != 0 && !gap) begin
        in_ch.valid     <= 1'b1;
        in_ch.raw_level <= sample_q.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin : watch
      debounce_t exp_res;
      out_ch.ready <= calm || ($urandom_range(99) >= GapPct);
      if (out_ch.valid && out_ch.ready) begin
        if (debounce_q.size() == 0) begin
          $error("result beat with no expected result pending");
          errors++;
        end else begin
          exp_res = debounce_q.pop_front();
          if (out_ch.is_active !== exp_res.is_active) begin
            $error("is_active: expected %0b, got %0b", exp_res.is_active, out_ch.is_active);
            errors++;
          end
          if (out_ch.rose_to_active !== exp_res.rose_to_active) begin
            $error("rose_to_active: expected %0b, got %0b",
                   exp_res.rose_to_active, out_ch.rose_to_active);
            errors++;
          end
          if (out_ch.fell_to_idle !== exp_res.fell_to_idle) begin
            $error("fell_to_idle: expected %0b, got %0b",
                   exp_res.fell_to_idle, out_ch.fell_to_idle);
            errors++;
          end
        end
      end
    end
  end

  task automatic wait_drained();
    while (sample_q.size() != 0 || in_ch.valid || debounce_q.size() != 0) @(posedge clk_i);
  endtask

  // Both registers are written back to back; only called with nothing in flight.
  task automatic set_config(logic ah, logic [CountW-1:0] cc);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgActiveHigh;
    cfg_wdata <= {{(CountW-1){1'b0}}, ah};
    @(posedge clk_i);
    cfg_idx   <= CfgConfirmCount;
    cfg_wdata <= cc;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    m_pol_high = ah;
    m_confirm  = cc;
  endtask

  task automatic push_level(bit level, logic ah, int len);
    repeat (len) sample_q.push_back(level ? ah : !ah);
  endtask

  // Mostly alternating runs sized around the confirm count, with bounces and noise.
  task automatic queue_presses(int n, logic ah, logic [CountW-1:0] cc);
    int  eff;
    int  pick;
    int  len;
    int  added;
    bit  level;
    eff   = int'(confirm_target(cc));
    added = 0;
    level = 1'($urandom_range(1));
    while (added < n) begin
      pick = $urandom_range(19);
      if (pick < 2) begin
        len = $urandom_range(8, 1);
        repeat (len) sample_q.push_back(1'($urandom_range(1)));
      end else begin
        level = !level;
        if (pick < 7) len = 1;
        else if (pick < 9) len = (eff > 1) ? eff - 1 : 1;
        else if (pick < 14) len = eff;
        else if (pick < 18) len = eff + $urandom_range(3, 1);
        else len = $urandom_range(3 * eff, 1);
        push_level(level, ah, len);
      end
      added += len;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: bounce on press, clean press, bounce on release, clean release.
    for (int i = 11; i >= 0; i--) sample_q.push_back(ResetSeq[i]);
    wait_drained();

    // Minimum confirm count: the change validates on the second sample.
    set_config(1'b1, MinCount);
    push_level(1'b1, 1'b1, 2);
    push_level(1'b0, 1'b1, 2);
    wait_drained();

    set_config(1'b0, 16'd0);
    queue_presses(200, 1'b0, 16'd0);
    wait_drained();

    set_config(1'b1, 16'd1);
    queue_presses(200, 1'b1, 16'd1);
    wait_drained();

    calm = 1'b1;
    set_config(1'b0, 16'd2);
    queue_presses(200, 1'b0, 16'd2);
    wait_drained();
    calm = 1'b0;

    set_config(1'b1, 16'd4);
    queue_presses(200, 1'b1, 16'd4);
    wait_drained();

    set_config(1'b0, 16'd5);
    queue_presses(200, 1'b0, 16'd5);
    wait_drained();

    // Long confirm count: settle to idle, then a full-length press.
    set_config(1'b1, 16'd100);
    push_level(1'b0, 1'b1, 100);
    push_level(1'b1, 1'b1, 100);
    push_level(1'b0, 1'b1, 3);
    wait_drained();

    set_config(1'b1, 16'd3);
    queue_presses(200, 1'b1, 16'd3);
    wait_drained();

    set_config(1'b0, 16'd9);
    queue_presses(100, 1'b0, 16'd9);
    wait_drained();

    set_config(1'b1, 16'd2);
    queue_presses(100, 1'b1, 16'd2);
    wait_drained();

    repeat (5) @(posedge clk_i);
    if (debounce_q.size() != 0) begin
      $error("%0d expected results never arrived", debounce_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/bde_pkg.sv
rtl/bde_in_if.sv
rtl/bde_out_if.sv
rtl/button_debounce_edge_detect_core.sv
rtl/bde_checker.sv
dv/tb_top.sv
